// ===== src/rmvm_pkg.sv =====
// ---------------------------------------------------------------------------
// rmvm_pkg: shared types and constants
// Widths, operation codes and the request/status structs of the shared
// arithmetic unit of the running mean and variance merge block.
// ---------------------------------------------------------------------------
package rmvm_pkg;

   localparam int FRAC_BITS = 16;
   localparam int K_W       = 20;
   localparam int VAL_W     = 48;
   localparam int SUM_W     = 64;
   localparam int CNT_W     = 48;
   localparam int WIDE_W    = 128;
   localparam int OPB_W     = 64;
   localparam int ITER_W    = 7;
   localparam int SQRT_ITER = (SUM_W + FRAC_BITS + 1) / 2;
   localparam int SQRT_SHL  = WIDE_W - 2 * SQRT_ITER;

   localparam logic [1:0] OP_MUL  = 2'd0;
   localparam logic [1:0] OP_DIV  = 2'd1;
   localparam logic [1:0] OP_SQRT = 2'd2;

   localparam logic [VAL_W-1:0] S48_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic [VAL_W-1:0] S48_MIN = {1'b1, {(VAL_W-1){1'b0}}};
   localparam logic [SUM_W-1:0] S64_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0] S64_MIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   typedef struct packed {
      logic              start;
      logic [1:0]        op;
      logic              wide;
      logic [WIDE_W-1:0] a;
      logic [OPB_W-1:0]  b;
   } eng_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } eng_sts_type;

endpackage

// ===== src/rmvm_req_if.sv =====
// ---------------------------------------------------------------------------
// rmvm_req_if: input channel
// Valid/ready channel carrying one partial block of statistics.
// ---------------------------------------------------------------------------
interface rmvm_req_if;
   logic                              valid;
   logic                              ready;
   logic [rmvm_pkg::K_W-1:0]          step_count;
   logic signed [rmvm_pkg::VAL_W-1:0] partial_sum;
   logic [rmvm_pkg::VAL_W-1:0]        partial_variance;
   logic signed [rmvm_pkg::VAL_W-1:0] instant_value;

   modport source (output valid, step_count, partial_sum, partial_variance,
                   instant_value, input ready);
   modport sink   (input valid, step_count, partial_sum, partial_variance,
                   instant_value, output ready);
endinterface

// ===== src/rmvm_rsp_if.sv =====
// ---------------------------------------------------------------------------
// rmvm_rsp_if: result channel
// Valid/ready channel carrying the running mean and standard deviation.
// ---------------------------------------------------------------------------
interface rmvm_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [rmvm_pkg::VAL_W-1:0] mean;
   logic [rmvm_pkg::VAL_W-1:0]        std_dev;
   logic                              count_saturated;

   modport source (output valid, mean, std_dev, count_saturated, input ready);
   modport sink   (input valid, mean, std_dev, count_saturated, output ready);
endinterface

// ===== src/rmvm_engine.sv =====
// ---------------------------------------------------------------------------
// rmvm_engine: shared iterative arithmetic unit
// Bit-serial saturating multiply, restoring divide and digit-by-digit
// square root, one bit (or root digit) per cycle.
// ---------------------------------------------------------------------------
module rmvm_engine (
   input  logic                             clock,
   input  logic                             reset,
   input  rmvm_pkg::eng_req_type            eng_req,
   output rmvm_pkg::eng_sts_type            eng_sts,
   output logic [rmvm_pkg::WIDE_W-1:0]      eng_res
);
   localparam int W = rmvm_pkg::WIDE_W;
   localparam int B = rmvm_pkg::OPB_W;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [rmvm_pkg::ITER_W-1:0] cnt_ff, cnt_in;
   logic [1:0]        op_ff;
   logic [W-1:0]      a_ff, acc_ff;
   logic [B-1:0]      b_ff;
   logic [B:0]        rem_ff;
   logic              sat_ff;

   logic [B:0]        r2_div, r2_sq, sub_l, sub_r;
   logic [B+1:0]      diff;
   logic              ge;
   logic [W:0]        msum;
   logic [rmvm_pkg::ITER_W-1:0] iter_last;

   always_comb begin
      r2_div = {rem_ff[B-1:0], acc_ff[W-1]};
      r2_sq  = {rem_ff[B-2:0], acc_ff[W-1:W-2]};
      if (op_ff == rmvm_pkg::OP_SQRT) begin
         sub_l = r2_sq;
         sub_r = {1'b0, b_ff[B-3:0], 2'b01};
      end else begin
         sub_l = r2_div;
         sub_r = {1'b0, b_ff};
      end
      diff = {1'b0, sub_l} - {1'b0, sub_r};
      ge   = !diff[B+1];
      msum = {1'b0, acc_ff[W-2:0], 1'b0} + (b_ff[B-1] ? {1'b0, a_ff} : {(W+1){1'b0}});
   end

   always_comb begin
      unique case (eng_req.op)
         rmvm_pkg::OP_MUL:  iter_last = rmvm_pkg::ITER_W'(B - 1);
         rmvm_pkg::OP_DIV:  iter_last = eng_req.wide ? rmvm_pkg::ITER_W'(W - 1)
                                                     : rmvm_pkg::ITER_W'(B - 1);
         default:           iter_last = rmvm_pkg::ITER_W'(rmvm_pkg::SQRT_ITER - 1);
      endcase
   end

   // done rises in the cycle after the last step, once the result has settled
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (eng_req.start) begin
         busy_in = 1'b1;
         cnt_in  = iter_last;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (eng_req.start) begin
         op_ff  <= eng_req.op;
         a_ff   <= eng_req.a;
         rem_ff <= '0;
         sat_ff <= 1'b0;
         unique case (eng_req.op)
            rmvm_pkg::OP_MUL: begin
               acc_ff <= '0;
               b_ff   <= eng_req.b;
            end
            rmvm_pkg::OP_DIV: begin
               acc_ff <= eng_req.wide ? eng_req.a : {eng_req.a[B-1:0], {(W-B){1'b0}}};
               b_ff   <= eng_req.b;
            end
            default: begin
               acc_ff <= eng_req.a << rmvm_pkg::SQRT_SHL;
               b_ff   <= '0;
            end
         endcase
      end else if (busy_ff) begin
         unique case (op_ff)
            rmvm_pkg::OP_MUL: begin
               acc_ff <= msum[W-1:0];
               b_ff   <= {b_ff[B-2:0], 1'b0};
               sat_ff <= sat_ff | acc_ff[W-1] | msum[W];
            end
            rmvm_pkg::OP_DIV: begin
               acc_ff <= {acc_ff[W-2:0], ge};
               rem_ff <= ge ? diff[B:0] : r2_div;
            end
            default: begin
               acc_ff <= {acc_ff[W-3:0], 2'b00};
               rem_ff <= ge ? diff[B:0] : r2_sq;
               b_ff   <= {b_ff[B-2:0], ge};
            end
         endcase
      end
   end

   always_comb begin
      eng_sts.busy = busy_ff;
      eng_sts.done = done_ff;
      unique case (op_ff)
         rmvm_pkg::OP_MUL:  eng_res = sat_ff ? {W{1'b1}} : acc_ff;
         rmvm_pkg::OP_DIV:  eng_res = acc_ff;
         default:           eng_res = {{(W-B){1'b0}}, b_ff};
      endcase
   end

endmodule

// ===== src/running_mean_variance_merge.sv =====
// ---------------------------------------------------------------------------
// running_mean_variance_merge: pairwise merge of block statistics
// Folds partial blocks into a running count, sum and variance sum and
// reports the running mean and standard deviation.
// ---------------------------------------------------------------------------
// One transfer on req is one partial block (step count, partial sum, partial
// variance sum, instantaneous value; all but the count Q.16 fixed point); every
// block yields exactly one transfer on rsp carrying the running mean, the
// standard deviation and a flag raised once the 48-bit count has saturated.
// Work runs on a single shared bit-serial unit (multiply, divide, square root,
// one bit per cycle) under a small sequencer, so req is ready only between
// blocks. A block runs three multiplies, four 64-bit divides, one 128-bit
// divide and a square root; with store mode on and a zero partial variance a
// further multiply is added, and the very first block (empty running count)
// skips the merge term. A finished result waits in the output register, so
// the next block may be taken while it is still held; a new result is held
// back only while the previous one is still unclaimed. store_mode is to be
// written through csr_wr_en/csr_wr_data only while the block is idle, by the
// user; the block itself does not enforce this.
module running_mean_variance_merge (
   input  logic        clock,
   input  logic        reset,
   rmvm_req_if.sink    req,
   rmvm_rsp_if.source  rsp,
   input  logic        csr_wr_en,
   input  logic [0:0]  csr_wr_data
);
   localparam int W  = rmvm_pkg::WIDE_W;
   localparam int SW = rmvm_pkg::SUM_W;
   localparam int VW = rmvm_pkg::VAL_W;
   localparam int CW = rmvm_pkg::CNT_W;
   localparam int KW = rmvm_pkg::K_W;

   localparam logic [VW:0] S48_MIN_U = {2'b01, {(VW-1){1'b0}}};

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_PMUL     = 4'd1;
   localparam logic [3:0] ST_MERGE    = 4'd2;
   localparam logic [3:0] ST_DIV_MO   = 4'd3;
   localparam logic [3:0] ST_DIV_MN   = 4'd4;
   localparam logic [3:0] ST_MUL_DD   = 4'd5;
   localparam logic [3:0] ST_MUL_M    = 4'd6;
   localparam logic [3:0] ST_DIV_K    = 4'd7;
   localparam logic [3:0] ST_MUL_N    = 4'd8;
   localparam logic [3:0] ST_FIN      = 4'd9;
   localparam logic [3:0] ST_DIV_MEAN = 4'd10;
   localparam logic [3:0] ST_DIV_VAR  = 4'd11;
   localparam logic [3:0] ST_SQRT     = 4'd12;
   localparam logic [3:0] ST_PUT      = 4'd13;

   logic [3:0]     state_ff, state_in;
   logic           store_mode_ff;
   logic           rsp_valid_ff, rsp_valid_in;

   // running state
   logic [SW-1:0]  sum_ff, var_ff;
   logic [CW-1:0]  count_ff;
   // per-block working registers
   logic [KW-1:0]  k_ff;
   logic [VW-1:0]  ps_ff, pv_ff;
   logic           inst_neg_ff;
   logic [SW-1:0]  snew_ff, vnew_ff, mo_ff;
   logic [CW:0]    n_ff;
   logic [VW-1:0]  mean_ff, std_ff;
   // output register
   logic [VW-1:0]  rsp_mean_ff, rsp_std_ff;
   logic           rsp_sat_ff;

   rmvm_pkg::eng_req_type eng_req;
   rmvm_pkg::eng_sts_type eng_sts;
   logic [W-1:0]   eng_res;

   rmvm_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .eng_req (eng_req),
      .eng_sts (eng_sts),
      .eng_res (eng_res)
   );

   logic           req_xfer, rsp_free;
   logic [KW-1:0]  k_eff;
   logic           inst_neg;
   logic [VW-1:0]  inst_mag;
   logic [W-1:0]   ps_lim;
   logic [VW-1:0]  ps_next;
   logic [SW:0]    sum65, v65, vt65;
   logic [SW-1:0]  snew_val, vnew_val, abs_sum, abs_snew, q64, q_neg, mn_val, d_val;
   logic [W-1:0]   t_shr;
   logic [SW-1:0]  t64;
   logic [CW-1:0]  cnt_val;
   logic [VW-1:0]  mean_val;
   logic [VW:0]    pos_lim;

   assign req_xfer = req.valid && req.ready;
   assign rsp_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE);

   always_comb begin
      k_eff    = (req.step_count == '0) ? KW'(1) : req.step_count;
      inst_neg = req.instant_value[VW-1];
      inst_mag = inst_neg ? (~req.instant_value + 1'b1) : req.instant_value;

      // stored partial sum: magnitude product against the signed limit
      ps_lim  = inst_neg_ff ? W'(S48_MIN_U) : W'(rmvm_pkg::S48_MAX);
      if (eng_res > ps_lim)
         ps_next = inst_neg_ff ? rmvm_pkg::S48_MIN : rmvm_pkg::S48_MAX;
      else
         ps_next = inst_neg_ff ? (~eng_res[VW-1:0] + 1'b1) : eng_res[VW-1:0];

      sum65 = {sum_ff[SW-1], sum_ff} + {{(SW+1-VW){ps_ff[VW-1]}}, ps_ff};
      if (sum65[SW] != sum65[SW-1])
         snew_val = sum65[SW] ? rmvm_pkg::S64_MIN : rmvm_pkg::S64_MAX;
      else
         snew_val = sum65[SW-1:0];
      v65      = {1'b0, var_ff} + {{(SW+1-VW){1'b0}}, pv_ff};
      vnew_val = v65[SW] ? {SW{1'b1}} : v65[SW-1:0];

      abs_sum  = sum_ff[SW-1] ? (~sum_ff + 1'b1) : sum_ff;
      abs_snew = snew_ff[SW-1] ? (~snew_ff + 1'b1) : snew_ff;
      q64      = eng_res[SW-1:0];
      q_neg    = ~q64 + 1'b1;
      mn_val   = snew_ff[SW-1] ? q_neg : q64;
      d_val    = ($signed(mo_ff) >= $signed(mn_val)) ? (mo_ff - mn_val) : (mn_val - mo_ff);

      t_shr = eng_res >> rmvm_pkg::FRAC_BITS;
      t64   = (|t_shr[W-1:SW]) ? {SW{1'b1}} : t_shr[SW-1:0];
      vt65  = {1'b0, vnew_ff} + {1'b0, t64};

      cnt_val = n_ff[CW] ? rmvm_pkg::CNT_MAX : n_ff[CW-1:0];

      // mean: saturate the quotient magnitude to the 48-bit signed range
      pos_lim = {1'b0, rmvm_pkg::S48_MAX};
      if (sum_ff[SW-1]) begin
         if (q64 > SW'(S48_MIN_U)) mean_val = rmvm_pkg::S48_MIN;
         else                      mean_val = q_neg[VW-1:0];
      end else begin
         if (q64 > SW'(pos_lim))   mean_val = rmvm_pkg::S48_MAX;
         else                      mean_val = q64[VW-1:0];
      end
   end

   // sequencer: advance on each finished unit operation, start the next one
   always_comb begin
      state_in     = state_ff;
      eng_req      = '0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (store_mode_ff && (req.partial_variance == '0)) begin
                  eng_req.start = 1'b1;
                  eng_req.op    = rmvm_pkg::OP_MUL;
                  eng_req.a     = W'(inst_mag);
                  eng_req.b     = rmvm_pkg::OPB_W'(k_eff);
                  state_in      = ST_PMUL;
               end else begin
                  state_in = ST_MERGE;
               end
            end
         end
         ST_PMUL: if (eng_sts.done) state_in = ST_MERGE;
         ST_MERGE: begin
            if (count_ff != '0) begin
               eng_req.start = 1'b1;
               eng_req.op    = rmvm_pkg::OP_DIV;
               eng_req.a     = W'(abs_sum);
               eng_req.b     = rmvm_pkg::OPB_W'(count_ff);
               state_in      = ST_DIV_MO;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_DIV_MO: begin
            if (eng_sts.done) begin
               eng_req.start = 1'b1;
               eng_req.op    = rmvm_pkg::OP_DIV;
               eng_req.a     = W'(abs_snew);
               eng_req.b     = rmvm_pkg::OPB_W'(n_ff);
               state_in      = ST_DIV_MN;
            end
         end
         ST_DIV_MN: begin
            if (eng_sts.done) begin
               eng_req.start = 1'b1;
               eng_req.op    = rmvm_pkg::OP_MUL;
               eng_req.a     = W'(d_val);
               eng_req.b     = d_val;
               state_in      = ST_MUL_DD;
            end
         end
         ST_MUL_DD: begin
            if (eng_sts.done) begin
               eng_req.start = 1'b1;
               eng_req.op    = rmvm_pkg::OP_MUL;
               eng_req.a     = eng_res;
               eng_req.b     = rmvm_pkg::OPB_W'(count_ff);
               state_in      = ST_MUL_M;
            end
         end
         ST_MUL_M: begin
            if (eng_sts.done) begin
               eng_req.start = 1'b1;
               eng_req.op    = rmvm_pkg::OP_DIV;
               eng_req.wide  = 1'b1;
               eng_req.a     = eng_res;
               eng_req.b     = rmvm_pkg::OPB_W'(k_ff);
               state_in      = ST_DIV_K;
            end
         end
         ST_DIV_K: begin
            if (eng_sts.done) begin
               eng_req.start = 1'b1;
               eng_req.op    = rmvm_pkg::OP_MUL;
               eng_req.a     = eng_res;
               eng_req.b     = rmvm_pkg::OPB_W'(n_ff);
               state_in      = ST_MUL_N;
            end
         end
         ST_MUL_N: if (eng_sts.done) state_in = ST_FIN;
         ST_FIN: begin
            eng_req.start = 1'b1;
            eng_req.op    = rmvm_pkg::OP_DIV;
            eng_req.a     = W'(abs_snew);
            eng_req.b     = rmvm_pkg::OPB_W'(cnt_val);
            state_in      = ST_DIV_MEAN;
         end
         ST_DIV_MEAN: begin
            if (eng_sts.done) begin
               eng_req.start = 1'b1;
               eng_req.op    = rmvm_pkg::OP_DIV;
               eng_req.a     = W'(var_ff);
               eng_req.b     = rmvm_pkg::OPB_W'(count_ff);
               state_in      = ST_DIV_VAR;
            end
         end
         ST_DIV_VAR: begin
            if (eng_sts.done) begin
               eng_req.start = 1'b1;
               eng_req.op    = rmvm_pkg::OP_SQRT;
               eng_req.a     = W'(q64) << rmvm_pkg::FRAC_BITS;
               state_in      = ST_SQRT;
            end
         end
         ST_SQRT: if (eng_sts.done) state_in = ST_PUT;
         ST_PUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state and running statistics
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         store_mode_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         sum_ff        <= '0;
         var_ff        <= '0;
         count_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) store_mode_ff <= csr_wr_data[0];
         // commit the merged block
         if (state_ff == ST_FIN) begin
            sum_ff   <= snew_ff;
            var_ff   <= vnew_ff;
            count_ff <= cnt_val;
         end
      end
   end

   // working registers: capture each result as its operation finishes
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         k_ff        <= k_eff;
         ps_ff       <= req.partial_sum;
         pv_ff       <= req.partial_variance;
         inst_neg_ff <= inst_neg;
      end
      if (state_ff == ST_PMUL && eng_sts.done) ps_ff <= ps_next;
      if (state_ff == ST_MERGE) begin
         snew_ff <= snew_val;
         vnew_ff <= vnew_val;
         n_ff    <= {1'b0, count_ff} + (CW+1)'(k_ff);
      end
      if (state_ff == ST_DIV_MO && eng_sts.done) mo_ff <= sum_ff[SW-1] ? q_neg : q64;
      if (state_ff == ST_MUL_N && eng_sts.done)
         vnew_ff <= vt65[SW] ? {SW{1'b1}} : vt65[SW-1:0];
      if (state_ff == ST_DIV_MEAN && eng_sts.done) mean_ff <= mean_val;
      if (state_ff == ST_SQRT && eng_sts.done) std_ff <= eng_res[VW-1:0];
      // hold the output register until the transfer completes
      if (state_ff == ST_PUT && rsp_free) begin
         rsp_mean_ff <= mean_ff;
         rsp_std_ff  <= std_ff;
         rsp_sat_ff  <= (count_ff == rmvm_pkg::CNT_MAX);
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.mean            = rsp_mean_ff;
   assign rsp.std_dev         = rsp_std_ff;
   assign rsp.count_saturated = rsp_sat_ff;

`ifndef SYNTHESIS
   a_idle_unit_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !eng_sts.busy)
      else $error("shared unit busy while sequencer idle");
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count_ff >= $past(count_ff)))
      else $error("running count decreased");
   a_var_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (var_ff >= $past(var_ff)))
      else $error("running variance decreased");
`endif

endmodule
